// ----- rtl/ncmdp_pkg.sv -----
package ncmdp_pkg;

    localparam int VECTOR_LENGTH = 128;
    localparam int MAX_CENTRES   = 1024;

    localparam int VALUE_W  = 16;
    localparam int ELEM_W   = $clog2(VECTOR_LENGTH);
    localparam int CENTRE_W = $clog2(MAX_CENTRES);
    localparam int COUNT_W  = $clog2(MAX_CENTRES + 1);
    localparam int PROD_W   = 2 * VALUE_W;
    localparam int SCORE_W  = PROD_W + ELEM_W;

    localparam int CB_ADDR_W = CENTRE_W + ELEM_W;
    localparam int CB_DEPTH  = MAX_CENTRES << ELEM_W;
    localparam int Q_DEPTH   = 1 << ELEM_W;

    localparam logic [ELEM_W-1:0] ELEM_LAST = ELEM_W'(VECTOR_LENGTH - 1);

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    // Read request from the search sequencer to both stores.
    typedef struct packed {
        logic                en;
        logic [CENTRE_W-1:0] centre;
        logic [ELEM_W-1:0]   element;
    } rd_req_t;

    // Status of the search engine toward the top level.
    typedef struct packed {
        logic busy;
        logic result_valid;
    } srch_status_t;

endpackage

// ----- rtl/ncmdp_ram.sv -----
module ncmdp_ram #(
    parameter int WIDTH  = 16,
    parameter int DEPTH  = 128,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- rtl/ncmdp_search.sv -----
module ncmdp_search (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic [ncmdp_pkg::CENTRE_W-1:0]       centre_last,
    output ncmdp_pkg::rd_req_t                   rd_req,
    input  logic [ncmdp_pkg::VALUE_W-1:0]        cb_data,
    input  logic [ncmdp_pkg::VALUE_W-1:0]        q_data,
    output ncmdp_pkg::srch_status_t              status,
    input  logic                                 result_taken,
    output logic [ncmdp_pkg::CENTRE_W-1:0]       result_index,
    output logic [ncmdp_pkg::SCORE_W-1:0]        result_score
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_RUN   = 4'b0010,
        S_DRAIN = 4'b0100,
        S_HOLD  = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic [ncmdp_pkg::CENTRE_W-1:0] centre_reg, centre_next;
    logic [ncmdp_pkg::ELEM_W-1:0]   elem_reg, elem_next;

    logic issue_last_elem;
    logic issue_final;

    // Stage 1: memory read data is valid.
    logic                           rd_valid_reg;
    logic                           rd_first_reg;
    logic                           rd_lastel_reg;
    logic                           rd_final_reg;
    logic [ncmdp_pkg::CENTRE_W-1:0] rd_centre_reg;

    // Stage 2: product registered.
    logic                           prod_valid_reg;
    logic                           prod_first_reg;
    logic                           prod_lastel_reg;
    logic                           prod_final_reg;
    logic [ncmdp_pkg::CENTRE_W-1:0] prod_centre_reg;
    logic [ncmdp_pkg::PROD_W-1:0]   prod_reg;

    // Stage 3: accumulation and finished sums.
    logic [ncmdp_pkg::SCORE_W-1:0]  acc_reg, acc_next;
    logic                           sum_valid_reg;
    logic                           sum_final_reg;
    logic [ncmdp_pkg::CENTRE_W-1:0] sum_centre_reg;
    logic [ncmdp_pkg::SCORE_W-1:0]  sum_reg;

    // Stage 4: running best.
    logic [ncmdp_pkg::SCORE_W-1:0]  best_score_reg;
    logic [ncmdp_pkg::CENTRE_W-1:0] best_index_reg;

    assign issue_last_elem = (elem_reg == ncmdp_pkg::ELEM_LAST);
    assign issue_final     = issue_last_elem && (centre_reg == centre_last);

    always_comb
    begin
        state_next  = state_reg;
        centre_next = centre_reg;
        elem_next   = elem_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next  = S_RUN;
                    centre_next = '0;
                    elem_next   = '0;
                end
            end
            S_RUN:
            begin
                if (issue_last_elem)
                begin
                    elem_next = '0;
                    if (issue_final)
                    begin
                        state_next = S_DRAIN;
                    end
                    else
                    begin
                        centre_next = centre_reg + 1'b1;
                    end
                end
                else
                begin
                    elem_next = elem_reg + 1'b1;
                end
            end
            S_DRAIN:
            begin
                if (sum_valid_reg && sum_final_reg)
                begin
                    state_next = S_HOLD;
                end
            end
            S_HOLD:
            begin
                if (result_taken)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        acc_next = ncmdp_pkg::SCORE_W'(prod_reg) + (prod_first_reg ? '0 : acc_reg);
    end

    assign rd_req.en      = (state_reg == S_RUN);
    assign rd_req.centre  = centre_reg;
    assign rd_req.element = elem_reg;

    assign status.busy         = (state_reg != S_IDLE);
    assign status.result_valid = (state_reg == S_HOLD);

    assign result_index = best_index_reg;
    assign result_score = best_score_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            centre_reg     <= '0;
            elem_reg       <= '0;
            rd_valid_reg   <= 1'b0;
            prod_valid_reg <= 1'b0;
            sum_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            centre_reg     <= centre_next;
            elem_reg       <= elem_next;
            rd_valid_reg   <= rd_req.en;
            prod_valid_reg <= rd_valid_reg;
            sum_valid_reg  <= prod_valid_reg && prod_lastel_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_first_reg  <= (elem_reg == '0);
        rd_lastel_reg <= issue_last_elem;
        rd_final_reg  <= issue_final;
        rd_centre_reg <= centre_reg;

        prod_reg        <= ncmdp_pkg::PROD_W'(cb_data) * ncmdp_pkg::PROD_W'(q_data);
        prod_first_reg  <= rd_first_reg;
        prod_lastel_reg <= rd_lastel_reg;
        prod_final_reg  <= rd_final_reg;
        prod_centre_reg <= rd_centre_reg;

        if (prod_valid_reg)
        begin
            acc_reg <= acc_next;
        end
        sum_reg        <= acc_next;
        sum_final_reg  <= prod_final_reg;
        sum_centre_reg <= prod_centre_reg;

        // Starting from zero lets centre 0 win through the same compare, and
        // greater-or-equal hands ties to the later centre.
        if (state_reg == S_IDLE && start)
        begin
            best_score_reg <= '0;
            best_index_reg <= '0;
        end
        else if (sum_valid_reg && (sum_reg >= best_score_reg))
        begin
            best_score_reg <= sum_reg;
            best_index_reg <= sum_centre_reg;
        end
    end

`ifndef ASSERT_OFF
    a_sum_only_in_search: assert property (@(posedge clk) disable iff (!rst_n)
        sum_valid_reg |-> (state_reg == S_RUN || state_reg == S_DRAIN))
        else $error("finished sum outside a search");

    a_final_sum_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (sum_valid_reg && sum_final_reg) |-> (state_reg == S_DRAIN))
        else $error("last centre finished before issue ended");

    a_best_never_drops: assert property (@(posedge clk) disable iff (!rst_n)
        sum_valid_reg |=> (best_score_reg >= $past(best_score_reg)))
        else $error("running best score decreased");

    a_hold_keeps_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_HOLD && !result_taken) |=>
            ($stable(best_score_reg) && $stable(best_index_reg)))
        else $error("result changed while waiting for the output register");
`endif

endmodule

// ----- rtl/nearest_centre_max_dot_product.sv -----
// Channel  Direction  Signals                                           Word
// -------  ---------  ------------------------------------------------  --------------------
// in       input      in_valid, in_ready, mode, centre_index,           one codebook or
//                     element_index, value                              query element
// out      output     out_valid, out_ready, best_index, best_score      one search result
// cfg      input      cfg_valid, cfg_ready, centre_count                number of centres
//
// A load word or a query word that is not the last element is only written into its
// memory. The last query element starts a search over N centres, N being the clamped
// centre count; the single read port of the codebook memory delivers one element per
// cycle into one multiply-accumulate unit. While a search runs or its result waits
// for the output register, in_ready is low; cfg_ready is always high.
// A finished result moves into the output register as soon as that register
// is free, so a stalled consumer holds back only the next search.
// Reset (rst_n, asynchronous, active low) sets the centre count to 1 and
// clears all control state; the codebook and query memories are not cleared.
module nearest_centre_max_dot_product (
    input  logic                                 clk,
    input  logic                                 rst_n,

    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [ncmdp_pkg::COUNT_W-1:0]        centre_count,

    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic                                 mode,
    input  logic [ncmdp_pkg::CENTRE_W-1:0]       centre_index,
    input  logic [ncmdp_pkg::ELEM_W-1:0]         element_index,
    input  logic [ncmdp_pkg::VALUE_W-1:0]        value,

    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [ncmdp_pkg::CENTRE_W-1:0]       best_index,
    output logic [ncmdp_pkg::SCORE_W-1:0]        best_score
);

    logic [ncmdp_pkg::COUNT_W-1:0]  centre_count_reg;
    logic [ncmdp_pkg::COUNT_W-1:0]  count_minus_one;
    logic [ncmdp_pkg::CENTRE_W-1:0] centre_last;

    logic in_accept;
    logic elem_ok;
    logic cb_we;
    logic q_we;
    logic start;

    ncmdp_pkg::rd_req_t      rd_req;
    ncmdp_pkg::srch_status_t status;

    logic [ncmdp_pkg::VALUE_W-1:0]  cb_data;
    logic [ncmdp_pkg::VALUE_W-1:0]  q_data;
    logic [ncmdp_pkg::CENTRE_W-1:0] result_index;
    logic [ncmdp_pkg::SCORE_W-1:0]  result_score;

    logic result_taken;
    logic out_load;
    logic out_valid_reg, out_valid_next;
    logic [ncmdp_pkg::CENTRE_W-1:0] best_index_reg;
    logic [ncmdp_pkg::SCORE_W-1:0]  best_score_reg;

    // Configuration is accepted at any time; the register reads as 1 after reset.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            centre_count_reg <= ncmdp_pkg::COUNT_W'(1);
        end
        else if (cfg_valid)
        begin
            centre_count_reg <= centre_count;
        end
    end

    // A count of zero searches one centre, and a count above the codebook
    // size searches the whole codebook.
    assign count_minus_one = centre_count_reg - 1'b1;

    always_comb
    begin
        priority if (centre_count_reg == '0)
        begin
            centre_last = '0;
        end
        else if (centre_count_reg > ncmdp_pkg::COUNT_W'(ncmdp_pkg::MAX_CENTRES))
        begin
            centre_last = ncmdp_pkg::CENTRE_W'(ncmdp_pkg::MAX_CENTRES - 1);
        end
        else
        begin
            centre_last = count_minus_one[ncmdp_pkg::CENTRE_W-1:0];
        end
    end

    // Input side: words are taken whenever the search engine is idle.
    assign in_ready  = !status.busy;
    assign in_accept = in_valid && in_ready;
    assign elem_ok   = (32'(element_index) < ncmdp_pkg::VECTOR_LENGTH);

    assign cb_we = in_accept && elem_ok && (mode == ncmdp_pkg::MODE_LOAD)
                   && (32'(centre_index) < ncmdp_pkg::MAX_CENTRES);
    assign q_we  = in_accept && elem_ok && (mode == ncmdp_pkg::MODE_QUERY);
    assign start = q_we && (element_index == ncmdp_pkg::ELEM_LAST);

    ncmdp_ram #(
        .WIDTH  (ncmdp_pkg::VALUE_W),
        .DEPTH  (ncmdp_pkg::CB_DEPTH),
        .ADDR_W (ncmdp_pkg::CB_ADDR_W)
    ) u_codebook (
        .clk   (clk),
        .we    (cb_we),
        .waddr ({centre_index, element_index}),
        .wdata (value),
        .re    (rd_req.en),
        .raddr ({rd_req.centre, rd_req.element}),
        .rdata (cb_data)
    );

    ncmdp_ram #(
        .WIDTH  (ncmdp_pkg::VALUE_W),
        .DEPTH  (ncmdp_pkg::Q_DEPTH),
        .ADDR_W (ncmdp_pkg::ELEM_W)
    ) u_query (
        .clk   (clk),
        .we    (q_we),
        .waddr (element_index),
        .wdata (value),
        .re    (rd_req.en),
        .raddr (rd_req.element),
        .rdata (q_data)
    );

    ncmdp_search u_search (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .centre_last  (centre_last),
        .rd_req       (rd_req),
        .cb_data      (cb_data),
        .q_data       (q_data),
        .status       (status),
        .result_taken (result_taken),
        .result_index (result_index),
        .result_score (result_score)
    );

    // Output register: the engine hands over its result when the register
    // is empty or is being emptied in this cycle.
    assign result_taken = !out_valid_reg || out_ready;
    assign out_load     = status.result_valid && result_taken;

    always_comb
    begin
        priority if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            best_index_reg <= result_index;
            best_score_reg <= result_score;
        end
    end

    assign out_valid  = out_valid_reg;
    assign best_index = best_index_reg;
    assign best_score = best_score_reg;

`ifndef ASSERT_OFF
    a_search_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> !in_ready)
        else $error("input still open after the last query word");

    a_load_into_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> !$past(out_load))
        else $error("result loaded over a word still waiting");
`endif

endmodule
